/* rtl/bbp_pkg.sv */
// Shared types and constants for the basic block partitioner.
// Used by bbp_match, bbp_checker and the basic_block_partitioner top level. No dependencies.
package bbp_pkg;

    // Field widths
    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 4;
    localparam int KIND_W    = 3;
    localparam int FIRST_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 144;

    // Instruction kind codes
    localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COND     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNCOND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INDIRECT = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CAPTURE,
        ST_SWEEP,
        ST_EMIT,
        ST_FINAL
    } state_t;

    // One request to the shared address match unit
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] cand_a;
        logic              en_a;
        logic [ADDR_W-1:0] cand_b;
        logic              en_b;
    } match_req_t;

endpackage

/* rtl/basic_block_partitioner.sv */
// Operation: instructions are stored while loading. After the list end, each later instruction
// passes through fetch and capture, a sweep of the stored entries through the shared match
// unit and an emit if it opens a block; the last block is emitted from a final state.
// Throughput: one instruction per cycle while loading; no input is taken during search.
// Reset: aresetn, synchronous, active low; clears the sequencer, counts and output valid.
// Depends on bbp_pkg, bbp_ram, bbp_match.
module basic_block_partitioner #(
    parameter int MAX_INSTRUCTIONS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // address[63:0], length[67:64], branch_target[131:68], zero pad
    input  logic [bbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind[2:0], has_target[3]
    input  logic [bbp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // block_start[63:0], block_end[127:64], first_index[133:128],
    // instr_count[140:134], zero pad
    output logic [bbp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // overflowed[0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    localparam int IW     = (MAX_INSTRUCTIONS > 1) ? $clog2(MAX_INSTRUCTIONS) : 1;
    localparam int CW     = $clog2(MAX_INSTRUCTIONS + 1);
    localparam int AW     = bbp_pkg::ADDR_W;
    localparam int LW     = bbp_pkg::LEN_W;
    localparam int MAIN_W = AW + LW;
    localparam int SIDE_W = AW + 2;

    // End address past an instruction, saturated at all ones
    function automatic logic [AW-1:0] end_addr(input logic [AW-1:0] a,
                                                input logic [LW-1:0] len);
        logic [LW-1:0] l;
        logic [AW:0]   sum;
        l   = (len == '0) ? LW'(1) : len;
        sum = {1'b0, a} + (AW+1)'(l);
        return sum[AW] ? '1 : sum[AW-1:0];
    endfunction

    // Input fields
    logic [AW-1:0]             in_addr;
    logic [LW-1:0]             in_len;
    logic [bbp_pkg::KIND_W-1:0] in_kind;
    logic                      in_has_tgt;
    logic [AW-1:0]             in_tgt;
    logic                      in_ends;
    logic                      in_tgt_ok;

    assign in_addr    = s_axis_tdata[AW-1:0];
    assign in_len     = s_axis_tdata[AW+LW-1:AW];
    assign in_tgt     = s_axis_tdata[2*AW+LW-1:AW+LW];
    assign in_kind    = s_axis_tuser[bbp_pkg::KIND_W-1:0];
    assign in_has_tgt = s_axis_tuser[bbp_pkg::KIND_W];
    assign in_ends    = (in_kind == bbp_pkg::KIND_RETURN) || (in_kind == bbp_pkg::KIND_COND) ||
                        (in_kind == bbp_pkg::KIND_UNCOND) || (in_kind == bbp_pkg::KIND_INDIRECT);
    assign in_tgt_ok  = in_has_tgt &&
                        ((in_kind == bbp_pkg::KIND_COND) || (in_kind == bbp_pkg::KIND_UNCOND));

    // Registers
    bbp_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   prev_ends_reg, prev_ends_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [IW-1:0]          j_reg, j_next;
    logic [AW-1:0]          addr0_reg, addr0_next;
    logic [AW-1:0]          key_reg, key_next;
    logic [LW-1:0]          cur_len_reg, cur_len_next;
    logic [AW-1:0]          prev_addr_reg, prev_addr_next;
    logic [LW-1:0]          prev_len_reg, prev_len_next;
    logic [AW-1:0]          open_addr_reg, open_addr_next;
    logic [IW-1:0]          open_idx_reg, open_idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [AW-1:0]          out_start_reg, out_start_next;
    logic [AW-1:0]          out_end_reg, out_end_next;
    logic [bbp_pkg::FIRST_W-1:0] out_first_reg, out_first_next;
    logic [bbp_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_ovf_reg, out_ovf_next;

    // Control
    logic accept, store, out_free, hit;
    logic [IW-1:0]          rd_idx;
    logic [MAIN_W-1:0]      main_wdata, main_rdata;
    logic [SIDE_W-1:0]      side_wdata, side_rdata;
    bbp_pkg::match_req_t    mreq;

    assign s_axis_tready = (state_reg == bbp_pkg::ST_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign store         = accept && (count_reg < CW'(MAX_INSTRUCTIONS));
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Stored entry: main = {length, address}, side = {follows_end, target_ok, target}
    assign main_wdata = {in_len, in_addr};
    assign side_wdata = {(count_reg != '0) && prev_ends_reg, in_tgt_ok, in_tgt};

    bbp_ram #(.WIDTH(MAIN_W), .DEPTH(MAX_INSTRUCTIONS)) u_main_ram (
        .aclk  (aclk),
        .we    (store),
        .waddr (count_reg[IW-1:0]),
        .wdata (main_wdata),
        .raddr (rd_idx),
        .rdata (main_rdata)
    );

    bbp_ram #(.WIDTH(SIDE_W), .DEPTH(MAX_INSTRUCTIONS)) u_side_ram (
        .aclk  (aclk),
        .we    (store),
        .waddr (count_reg[IW-1:0]),
        .wdata (side_wdata),
        .raddr (rd_idx),
        .rdata (side_rdata)
    );

    bbp_match u_match (
        .req (mreq),
        .hit (hit)
    );

    // Match request: first-address check on capture, stored entry during sweep
    always_comb begin
        mreq = '0;
        if (state_reg == bbp_pkg::ST_CAPTURE) begin
            mreq.key    = main_rdata[AW-1:0];
            mreq.cand_a = addr0_reg;
            mreq.en_a   = 1'b1;
        end else begin
            mreq.key    = key_reg;
            mreq.cand_a = side_rdata[AW-1:0];
            mreq.en_a   = side_rdata[AW];
            mreq.cand_b = main_rdata[AW-1:0];
            mreq.en_b   = side_rdata[AW+1];
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbp_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            prev_ends_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            prev_ends_reg <= prev_ends_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        addr0_reg     <= addr0_next;
        key_reg       <= key_next;
        cur_len_reg   <= cur_len_next;
        prev_addr_reg <= prev_addr_next;
        prev_len_reg  <= prev_len_next;
        open_addr_reg <= open_addr_next;
        open_idx_reg  <= open_idx_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_first_reg <= out_first_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        prev_ends_next = prev_ends_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        addr0_next     = addr0_reg;
        key_next       = key_reg;
        cur_len_next   = cur_len_reg;
        prev_addr_next = prev_addr_reg;
        prev_len_next  = prev_len_reg;
        open_addr_next = open_addr_reg;
        open_idx_next  = open_idx_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_first_next = out_first_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        rd_idx         = '0;

        unique case (state_reg)
            bbp_pkg::ST_LOAD: begin
                if (accept) begin
                    if (store) begin
                        count_next     = count_reg + CW'(1);
                        prev_ends_next = in_ends;
                        if (count_reg == '0) begin
                            addr0_next     = in_addr;
                            key_next       = in_addr;
                            cur_len_next   = in_len;
                            open_addr_next = in_addr;
                            open_idx_next  = '0;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        i_next     = CW'(1);
                        state_next = bbp_pkg::ST_FETCH;
                    end
                end
            end

            // Read instruction i, or close the list when all are checked
            bbp_pkg::ST_FETCH: begin
                rd_idx = i_reg[IW-1:0];
                if (i_reg == count_reg) begin
                    state_next = bbp_pkg::ST_FINAL;
                end else begin
                    state_next = bbp_pkg::ST_CAPTURE;
                end
            end

            // Latch instruction i, check against the first address, start sweep
            bbp_pkg::ST_CAPTURE: begin
                rd_idx         = '0;
                prev_addr_next = key_reg;
                prev_len_next  = cur_len_reg;
                key_next       = main_rdata[AW-1:0];
                cur_len_next   = main_rdata[MAIN_W-1:AW];
                j_next         = '0;
                if (hit) begin
                    state_next = bbp_pkg::ST_EMIT;
                end else begin
                    state_next = bbp_pkg::ST_SWEEP;
                end
            end

            // One stored entry per cycle through the match unit
            bbp_pkg::ST_SWEEP: begin
                rd_idx = j_reg + IW'(1);
                if (hit) begin
                    state_next = bbp_pkg::ST_EMIT;
                end else if ((CW'(j_reg) + CW'(1)) == count_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = bbp_pkg::ST_FETCH;
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end

            // Instruction i is a leader: close the open block
            bbp_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_start_next = open_addr_reg;
                    out_end_next   = end_addr(prev_addr_reg, prev_len_reg);
                    out_first_next = bbp_pkg::FIRST_W'(open_idx_reg);
                    out_count_next = bbp_pkg::COUNT_W'(i_reg - CW'(open_idx_reg));
                    out_last_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    open_addr_next = key_reg;
                    open_idx_next  = i_reg[IW-1:0];
                    i_next         = i_reg + CW'(1);
                    state_next     = bbp_pkg::ST_FETCH;
                end
            end

            // Last block of the list, then clear for the next list
            bbp_pkg::ST_FINAL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_start_next = open_addr_reg;
                    out_end_next   = end_addr(key_reg, cur_len_reg);
                    out_first_next = bbp_pkg::FIRST_W'(open_idx_reg);
                    out_count_next = bbp_pkg::COUNT_W'(count_reg - CW'(open_idx_reg));
                    out_last_next  = 1'b1;
                    out_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    prev_ends_next = 1'b0;
                    state_next     = bbp_pkg::ST_LOAD;
                end
            end

            default: begin
                state_next = bbp_pkg::ST_LOAD;
            end
        endcase
    end

    // Output channel
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_first_reg, out_end_reg, out_start_reg};

endmodule

/* rtl/bbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bbp_match.sv */
// Shared address match unit: compares one key against up to two candidates.
// Depends on bbp_pkg.
module bbp_match (
    input  bbp_pkg::match_req_t req,
    output logic                hit
);

    // Either enabled candidate equal to the key is a hit
    assign hit = (req.en_a && (req.cand_a == req.key)) ||
                 (req.en_b && (req.cand_b == req.key));

endmodule

/* rtl/bbp_checker.sv */
// Port-level checks for basic_block_partitioner, attached by bind.
// Depends on bbp_pkg and the basic_block_partitioner ports.
module bbp_checker #(
    parameter int MAX_INSTRUCTIONS = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tlast,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [bbp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                    m_axis_tuser,
    input logic                          m_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);

    logic [bbp_pkg::FIRST_W-1:0] first_idx;
    logic [bbp_pkg::COUNT_W-1:0] blk_count;
    logic [bbp_pkg::COUNT_W:0]   blk_span;

    assign first_idx = m_axis_tdata[133:128];
    assign blk_count = m_axis_tdata[140:134];
    assign blk_span  = (bbp_pkg::COUNT_W+1)'(first_idx) + (bbp_pkg::COUNT_W+1)'(blk_count);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Every block holds at least one instruction
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> blk_count != '0)
        else $error("empty block");

    // A block never reaches past the list capacity
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> blk_span <= (bbp_pkg::COUNT_W+1)'(MAX_INSTRUCTIONS))
        else $error("block exceeds capacity");

    // Accepting a list end deasserts input ready
    a_close_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after list end");

endmodule

bind basic_block_partitioner bbp_checker #(.MAX_INSTRUCTIONS(MAX_INSTRUCTIONS)) u_bbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

/* tb/sv/basic_block_partitioner_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for basic_block_partitioner: streams instruction lists in,
// predicts the basic blocks of each list and compares every emitted block.
// Depends on bbp_pkg and the basic_block_partitioner RTL.
module basic_block_partitioner_test;

    localparam int MAX_INSTR   = 64;
    localparam int IDLE_PCT    = 37;
    localparam int RAND_ITEMS  = 370;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT = 50000;
    localparam int TAIL_CYCLES = 4 * MAX_INSTR;

    // Kind codes with no meaning of their own; they behave as plain instructions
    localparam logic [bbp_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [bbp_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [bbp_pkg::ADDR_W-1:0] addr;
        logic [bbp_pkg::LEN_W-1:0]  len;
        logic [bbp_pkg::KIND_W-1:0] kind;
        logic                       has_tgt;
        logic [bbp_pkg::ADDR_W-1:0] tgt;
        logic                       last;
    } instr_t;

    typedef struct packed {
        logic [bbp_pkg::ADDR_W-1:0]  block_start;
        logic [bbp_pkg::ADDR_W-1:0]  block_end;
        logic [bbp_pkg::FIRST_W-1:0] first_index;
        logic [bbp_pkg::COUNT_W-1:0] instr_count;
        logic                        final_block;
        logic                        overflowed;
    } block_t;

    // Predicts the blocks of each list and checks emitted blocks in order
    class block_scoreboard;
        instr_t list_q[$];
        bit     dropped;
        block_t expected_blocks[$];
        int     mismatches;
        int     blocks_checked;
        int     overflow_lists;

        function int pending();
            return expected_blocks.size();
        endfunction

        // End address past an instruction, saturating at all ones
        function logic [bbp_pkg::ADDR_W-1:0] end_addr(instr_t it);
            logic [bbp_pkg::ADDR_W:0] sum;
            sum = {1'b0, it.addr} + ((it.len == '0) ? 65'd1 : {61'd0, it.len});
            return sum[bbp_pkg::ADDR_W] ? '1 : sum[bbp_pkg::ADDR_W-1:0];
        endfunction

        function bit is_leader(logic [bbp_pkg::ADDR_W-1:0] a);
            int n;
            logic [bbp_pkg::KIND_W-1:0] k;
            n = list_q.size();
            if (a == list_q[0].addr) return 1'b1;
            for (int j = 0; j < n; j++) begin
                k = list_q[j].kind;
                if ((k == bbp_pkg::KIND_COND || k == bbp_pkg::KIND_UNCOND) &&
                    list_q[j].has_tgt && list_q[j].tgt == a)
                    return 1'b1;
                if (k >= bbp_pkg::KIND_RETURN && k <= bbp_pkg::KIND_INDIRECT && j + 1 < n &&
                    list_q[j + 1].addr == a)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void add_block(int first, int last, bit fin);
            block_t b;
            b.block_start = list_q[first].addr;
            b.block_end   = end_addr(list_q[last]);
            b.first_index = bbp_pkg::FIRST_W'(first);
            b.instr_count = bbp_pkg::COUNT_W'(last - first + 1);
            b.final_block = fin;
            b.overflowed  = dropped;
            expected_blocks.insert(expected_blocks.size(), b);
        endfunction

        // Record an accepted instruction; a list end yields all its blocks
        function void note_instr(instr_t it);
            int n;
            int first;
            if (list_q.size() < MAX_INSTR) list_q.insert(list_q.size(), it);
            else dropped = 1'b1;
            if (!it.last) return;
            n = list_q.size();
            first = 0;
            for (int i = 1; i < n; i++) begin
                if (is_leader(list_q[i].addr)) begin
                    add_block(first, i - 1, 1'b0);
                    first = i;
                end
            end
            add_block(first, n - 1, 1'b1);
            if (dropped) overflow_lists++;
            list_q.delete();
            dropped = 1'b0;
        endfunction

        function void check_block(block_t got);
            block_t exp_b;
            if (expected_blocks.size() == 0) begin
                $error("unexpected block: start %h end %h index %0d count %0d",
                       got.block_start, got.block_end, got.first_index, got.instr_count);
                mismatches++;
                return;
            end
            exp_b = expected_blocks.pop_front();
            blocks_checked++;
            if (got.block_start !== exp_b.block_start) begin
                $error("block_start expected %h actual %h", exp_b.block_start, got.block_start);
                mismatches++;
            end
            if (got.block_end !== exp_b.block_end) begin
                $error("block_end expected %h actual %h", exp_b.block_end, got.block_end);
                mismatches++;
            end
            if (got.first_index !== exp_b.first_index) begin
                $error("first_index expected %0d actual %0d", exp_b.first_index,
                       got.first_index);
                mismatches++;
            end
            if (got.instr_count !== exp_b.instr_count) begin
                $error("instr_count expected %0d actual %0d", exp_b.instr_count,
                       got.instr_count);
                mismatches++;
            end
            if (got.final_block !== exp_b.final_block) begin
                $error("final_block expected %0b actual %0b", exp_b.final_block,
                       got.final_block);
                mismatches++;
            end
            if (got.overflowed !== exp_b.overflowed) begin
                $error("overflowed expected %0b actual %0b", exp_b.overflowed, got.overflowed);
                mismatches++;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [bbp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [bbp_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bbp_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                    m_axis_tuser;
    logic                          m_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;

    block_scoreboard sb = new();
    instr_t          list_buf[$];
    int              idle_pct = IDLE_PCT;
    int              items_sent;
    int              lists_sent;
    int              hold_left;
    bit              hold_done;
    bit              drain_failed;

    basic_block_partitioner #(
        .MAX_INSTRUCTIONS(MAX_INSTR)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure plus one long hold-off once blocks flow
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && sb.blocks_checked >= 25) begin
            m_axis_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_block({m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tdata[133:128],
                            m_axis_tdata[140:134], m_axis_tlast, m_axis_tuser[0]});
    end

    function instr_t mk(logic [bbp_pkg::ADDR_W-1:0] addr, logic [bbp_pkg::LEN_W-1:0] len,
                        logic [bbp_pkg::KIND_W-1:0] kind, logic has_tgt,
                        logic [bbp_pkg::ADDR_W-1:0] tgt, logic last);
        instr_t it;
        it = '{addr: addr, len: len, kind: kind, has_tgt: has_tgt, tgt: tgt, last: last};
        return it;
    endfunction

    function logic [bbp_pkg::ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Plausible code: mostly sequential addresses, targets mostly inside the list
    function void fill_flow_list(int n);
        instr_t                     it;
        logic [bbp_pkg::ADDR_W-1:0] cur;
        int                         r;
        list_buf.delete();
        cur = ($urandom_range(3) == 0) ? ('1 - bbp_pkg::ADDR_W'($urandom_range(200)))
                                       : rand_addr();
        for (int i = 0; i < n; i++) begin
            it.addr = (i > 0 && $urandom_range(9) == 0) ? list_buf[$urandom_range(i - 1)].addr
                                                        : cur;
            it.len  = bbp_pkg::LEN_W'($urandom_range(15));
            cur     = cur + ((it.len == '0) ? 64'd1 : 64'(it.len));
            r = $urandom_range(99);
            if (r < 55)      it.kind = bbp_pkg::KIND_OTHER;
            else if (r < 65) it.kind = bbp_pkg::KIND_COND;
            else if (r < 73) it.kind = bbp_pkg::KIND_UNCOND;
            else if (r < 80) it.kind = bbp_pkg::KIND_RETURN;
            else if (r < 87) it.kind = bbp_pkg::KIND_INDIRECT;
            else it.kind = bbp_pkg::KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
            it.has_tgt = ($urandom_range(3) != 0);
            it.tgt  = '0;
            it.last = (i == n - 1);
            list_buf.insert(list_buf.size(), it);
        end
        foreach (list_buf[i]) begin
            r = $urandom_range(99);
            if (r < 70)      list_buf[i].tgt = list_buf[$urandom_range(n - 1)].addr;
            else if (r < 85) list_buf[i].tgt = rand_addr();
            else             list_buf[i].tgt = list_buf[i].addr + 64'd1;
        end
    endfunction

    // Noise: every field random
    function void fill_noise_list(int n);
        list_buf.delete();
        for (int i = 0; i < n; i++)
            list_buf.insert(list_buf.size(),
                            mk(rand_addr(), bbp_pkg::LEN_W'($urandom_range(15)),
                               bbp_pkg::KIND_W'($urandom_range(7)), 1'($urandom_range(1)),
                               rand_addr(), i == n - 1));
    endfunction

    task automatic send_instr(input instr_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {4'b0, it.tgt, it.len, it.addr};
        s_axis_tuser  <= {it.has_tgt, it.kind};
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_instr(it);
        items_sent++;
    endtask

    task automatic send_list();
        foreach (list_buf[i]) send_instr(list_buf[i]);
        lists_sent++;
    endtask

    // Sender pause until every predicted block has been seen
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int n;
        int rand_start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single instruction at the top of the address space: end saturates
        list_buf = '{mk('1, 4'd15, bbp_pkg::KIND_OTHER, 1'b0, '0, 1'b1)};
        send_list();

        // All kinds but unconditional: zero length, target inside, indirect target ignored,
        // target outside the list, duplicate of the first address, spare kinds
        list_buf = '{
            mk(64'h1000, 4'd0,  bbp_pkg::KIND_OTHER,    1'b0, 64'h0,         1'b0),
            mk(64'h1001, 4'd2,  bbp_pkg::KIND_COND,     1'b1, 64'h1007,      1'b0),
            mk(64'h1003, 4'd4,  bbp_pkg::KIND_OTHER,    1'b0, 64'h0,         1'b0),
            mk(64'h1007, 4'd1,  bbp_pkg::KIND_RETURN,   1'b0, 64'h0,         1'b0),
            mk(64'h1008, 4'd3,  bbp_pkg::KIND_INDIRECT, 1'b1, 64'h100C,      1'b0),
            mk(64'h100B, 4'd5,  KIND_SPARE_HI,          1'b0, 64'h0,         1'b0),
            mk(64'h1010, 4'd2,  bbp_pkg::KIND_COND,     1'b1, 64'hDEAD_0000, 1'b0),
            mk(64'h1012, 4'd2,  bbp_pkg::KIND_OTHER,    1'b0, 64'h0,         1'b0),
            mk(64'h1000, 4'd1,  KIND_SPARE_LO,          1'b0, 64'h0,         1'b0),
            mk(64'h1014, 4'd15, KIND_SPARE_HI,          1'b1, 64'h1014,      1'b1)
        };
        send_list();

        // Field extremes: zero and all-ones addresses and targets
        list_buf = '{
            mk(64'h0, 4'd15, bbp_pkg::KIND_UNCOND, 1'b1, '1,    1'b0),
            mk('1,    4'd15, bbp_pkg::KIND_RETURN, 1'b1, 64'h0, 1'b1)
        };
        send_list();

        // Target field on plain instructions, with and without the has-target flag
        list_buf = '{
            mk(64'h2000, 4'd4, bbp_pkg::KIND_OTHER, 1'b1, 64'h2008, 1'b0),
            mk(64'h2004, 4'd4, bbp_pkg::KIND_OTHER, 1'b0, 64'h2008, 1'b0),
            mk(64'h2008, 4'd4, bbp_pkg::KIND_OTHER, 1'b0, 64'h0,    1'b1)
        };
        send_list();
        wait_drained();

        // Random lists: mostly plausible code, some noise, a few at or past capacity
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS) begin
            if (lists_sent == 6)      n = MAX_INSTR + 2;
            else if (lists_sent == 8) n = MAX_INSTR;
            else if ($urandom_range(99) < 88) n = $urandom_range(12, 1);
            else if ($urandom_range(1) == 0)  n = MAX_INSTR;
            else n = $urandom_range(MAX_INSTR + 6, MAX_INSTR + 1);
            if ($urandom_range(99) < 20) fill_noise_list(n);
            else fill_flow_list(n);
            idle_pct = (lists_sent >= 13 && lists_sent < 20) ? 0 : IDLE_PCT;
            send_list();
            if (lists_sent == 12) wait_drained();
        end
        s_axis_tvalid <= 1'b0;
        idle_pct = IDLE_PCT;

        // Drain with a limit, then watch for stray blocks
        n = 0;
        while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() > 0) begin
            $error("%0d expected blocks never arrived", sb.pending());
            drain_failed = 1'b1;
        end

        $display("Sent %0d lists (%0d past capacity), %0d instructions in all.",
                 lists_sent, sb.overflow_lists, items_sent);
        $display("Checked %0d blocks with random stalls on both sides.", sb.blocks_checked);
        if (sb.mismatches == 0 && !drain_failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/bbp_pkg.sv
rtl/bbp_ram.sv
rtl/bbp_match.sv
rtl/basic_block_partitioner.sv
rtl/bbp_checker.sv
tb/sv/basic_block_partitioner_test.sv
